/* rtl/dual_root_reachability_bfs_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the two-root reachability block
// Shared helpers so every checker writes properties the same way.
// ----------------------------------------------------------------------------
`ifndef DUAL_ROOT_REACHABILITY_BFS_DEFINES_SVH
`define DUAL_ROOT_REACHABILITY_BFS_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DRRB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define DRRB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/drrb_pkg.sv */
// ----------------------------------------------------------------------------
// drrb_pkg
// Widths, command codes and register indexes of the reachability block.
// ----------------------------------------------------------------------------
package drrb_pkg;

  localparam int unsigned ID_W        = 11;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_TOTAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_SECOND = 2'd2;

  localparam logic [1:0] CLASS_BOTH    = 2'd0;
  localparam logic [1:0] CLASS_ONE     = 2'd1;
  localparam logic [1:0] CLASS_NEITHER = 2'd2;

endpackage

/* rtl/drrb_ram.sv */
// ----------------------------------------------------------------------------
// drrb_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/dual_root_reachability_bfs.sv */
// Throughput: one command at a time; the next beat is taken once the result is out.
// The node-list, visited and ring RAMs have one read port each; the walk is bound
// by that single read per cycle. Reset runs a clearing pass over the list heads
// and visited maps with tready low.
// ----------------------------------------------------------------------------
// dual_root_reachability_bfs
// Edge store with per-head linked lists and two reverse breadth-first walks.
// ----------------------------------------------------------------------------
module dual_root_reachability_bfs
  import drrb_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // cfg port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ID_W-1:0]        cfg_data_i,
  // in: cmd[1:0], edge_tail[12:2], edge_head[23:13], query_node[34:24], pad
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // out: edge_accepted[0], reaches_first[1], reaches_second[2],
  //      node_class[4:3], shared_exists[5], pad
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned NAW = $clog2(MAX_NODES);
  localparam int unsigned NCW = NAW + 1;
  localparam int unsigned EIW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EDW = EIW + ID_W;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_ADD, S_QRY, S_WINIT, S_POP, S_POPW, S_HEADW,
    S_EDGE, S_EDGEW, S_SEENW, S_SCAN, S_SCANW
  } state_e;

  // node id -> RAM address (ids start at 1)
  function automatic logic [NAW-1:0] node_addr(input logic [ID_W-1:0] id);
    logic [31:0] t;
    t = 32'(id) - 32'd1;
    return t[NAW-1:0];
  endfunction

  state_e          state_q;
  logic [NCW-1:0]  cnt_q;
  logic            sw_head_q, sw_seen_q, sw_reset_q;
  logic [ID_W-1:0] node_total_q, root_first_q, root_second_q;
  logic [EIW-1:0]  stored_q;
  logic            shared_q;
  logic            sel_q;
  logic [NCW-1:0]  rd_q, wr_q;
  logic [EIW-1:0]  e_q;
  logic [ID_W-1:0] src_q, tail_q, head_q;
  logic            q_ok_q;
  logic            out_valid_q, acc_q, rf_q, rs_q;
  logic [1:0]      cls_q;

  logic [ID_W-1:0] nt, root;
  logic            in_fire;
  cmd_e            in_cmd;
  logic [ID_W-1:0] in_tail, in_head, in_qn;

  // RAM ports
  logic           hd_we;   logic [NAW-1:0] hd_wa, hd_ra; logic [EIW-1:0] hd_wd, hd_rd;
  logic           ed_we;   logic [EAW-1:0] ed_wa, ed_ra; logic [EDW-1:0] ed_wd, ed_rd;
  logic           s1_we, s2_we, sn_wd; logic [NAW-1:0] sn_wa, sn_ra;
  logic           s1_rd, s2_rd;
  logic           rg_we;   logic [NAW-1:0] rg_wa, rg_ra; logic [ID_W-1:0] rg_wd, rg_rd;

  logic [EIW-1:0]  ed_next;
  logic [ID_W-1:0] ed_src;
  logic            seen_sel;

  assign nt = (32'(node_total_q) > 32'(MAX_NODES)) ? ID_W'(MAX_NODES) : node_total_q;
  assign root = sel_q ? root_second_q : root_first_q;
  assign in_cmd  = cmd_e'(s_axis_tdata_i[1:0]);
  assign in_tail = s_axis_tdata_i[12:2];
  assign in_head = s_axis_tdata_i[23:13];
  assign in_qn   = s_axis_tdata_i[34:24];
  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign ed_next = ed_rd[EDW-1:ID_W];
  assign ed_src  = ed_rd[ID_W-1:0];
  assign seen_sel = sel_q ? s2_rd : s1_rd;

  // helpers: node in use, edge endpoint storable
  function automatic logic in_use(input logic [ID_W-1:0] id, input logic [ID_W-1:0] n);
    return (id != '0) && (id <= n);
  endfunction
  function automatic logic storable(input logic [ID_W-1:0] id);
    return (id != '0) && (32'(id) <= 32'(MAX_NODES));
  endfunction

  // ---------------------------------------------------------------------------
  // RAM control, decoded from the sequencer state
  // ---------------------------------------------------------------------------
  always_comb begin
    hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
    ed_we = 1'b0; ed_wa = stored_q[EAW-1:0]; ed_wd = {hd_rd, tail_q}; ed_ra = '0;
    s1_we = 1'b0; s2_we = 1'b0; sn_wa = '0; sn_wd = 1'b0; sn_ra = '0;
    rg_we = 1'b0; rg_wa = wr_q[NAW-1:0]; rg_wd = src_q; rg_ra = rd_q[NAW-1:0];
    unique case (state_q)
      S_SWEEP: begin
        hd_we = sw_head_q; hd_wa = cnt_q[NAW-1:0];
        s1_we = sw_seen_q; s2_we = sw_seen_q; sn_wa = cnt_q[NAW-1:0];
      end
      S_IDLE: begin
        hd_ra = node_addr(in_head);
        sn_ra = node_addr(in_qn);
      end
      S_ADD: begin
        ed_we = 1'b1;
        hd_we = 1'b1; hd_wa = node_addr(head_q); hd_wd = stored_q + 1'b1;
      end
      S_WINIT: begin
        if (in_use(root, nt)) begin
          s1_we = !sel_q; s2_we = sel_q; sn_wa = node_addr(root); sn_wd = 1'b1;
          rg_we = 1'b1; rg_wa = '0; rg_wd = root;
        end
      end
      S_POPW:  hd_ra = node_addr(rg_rd);
      S_EDGE: begin
        ed_ra = EAW'(32'(e_q) - 32'd1);
      end
      S_EDGEW: sn_ra = node_addr(ed_src);
      S_SEENW: begin
        if (!seen_sel && (32'(wr_q) < 32'(MAX_NODES))) begin
          s1_we = !sel_q; s2_we = sel_q; sn_wa = node_addr(src_q); sn_wd = 1'b1;
          rg_we = 1'b1;
        end
      end
      S_SCAN:  sn_ra = cnt_q[NAW-1:0];
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer, config registers and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;  cnt_q <= '0;
      sw_head_q <= 1'b1; sw_seen_q <= 1'b1; sw_reset_q <= 1'b1;
      node_total_q <= ID_W'(1024); root_first_q <= ID_W'(1); root_second_q <= ID_W'(1);
      stored_q <= '0; shared_q <= 1'b0; sel_q <= 1'b0;
      rd_q <= '0; wr_q <= '0; out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_NODE_TOTAL:  node_total_q  <= cfg_data_i;
          REG_ROOT_FIRST:  root_first_q  <= cfg_data_i;
          REG_ROOT_SECOND: root_second_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_SWEEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (32'(cnt_q) == MAX_NODES - 1) begin
            cnt_q <= '0; sw_reset_q <= 1'b0;
            if (sw_reset_q) state_q <= S_IDLE;
            else if (sw_seen_q) begin
              sel_q <= 1'b0; state_q <= S_WINIT;
            end else begin
              out_valid_q <= 1'b1; acc_q <= 1'b0; rf_q <= 1'b0; rs_q <= 1'b0;
              cls_q <= CLASS_BOTH; state_q <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            tail_q <= in_tail; head_q <= in_head;
            q_ok_q <= in_use(in_qn, nt);
            acc_q <= 1'b0; rf_q <= 1'b0; rs_q <= 1'b0; cls_q <= CLASS_BOTH;
            unique case (in_cmd)
              CMD_CLEAR: begin
                stored_q <= '0; cnt_q <= '0;
                sw_head_q <= 1'b1; sw_seen_q <= 1'b0; state_q <= S_SWEEP;
              end
              CMD_ADD: begin
                if ((32'(stored_q) < 32'(MAX_EDGES)) && storable(in_tail) && storable(in_head))
                  state_q <= S_ADD;
                else
                  out_valid_q <= 1'b1;  // refused
              end
              CMD_RUN: begin
                shared_q <= 1'b0; cnt_q <= '0;
                sw_head_q <= 1'b0; sw_seen_q <= 1'b1; state_q <= S_SWEEP;
              end
              CMD_QUERY: state_q <= S_QRY;
              default: ;
            endcase
          end
        end
        S_ADD: begin
          stored_q <= stored_q + 1'b1;
          out_valid_q <= 1'b1; acc_q <= 1'b1; state_q <= S_IDLE;
        end
        S_QRY: begin
          out_valid_q <= 1'b1;
          rf_q <= q_ok_q && s1_rd;
          rs_q <= q_ok_q && s2_rd;
          if (q_ok_q && s1_rd && s2_rd) cls_q <= CLASS_BOTH;
          else if ((q_ok_q && (s1_rd || s2_rd)) || shared_q) cls_q <= CLASS_ONE;
          else cls_q <= CLASS_NEITHER;
          state_q <= S_IDLE;
        end
        S_WINIT: begin
          rd_q <= '0;
          if (in_use(root, nt)) begin
            wr_q <= NCW'(1); state_q <= S_POP;
          end else begin
            wr_q <= '0;
            if (!sel_q) sel_q <= 1'b1;
            else begin
              cnt_q <= '0; state_q <= S_SCAN;
            end
          end
        end
        S_POP: begin
          if (rd_q < wr_q) begin
            rd_q <= rd_q + 1'b1; state_q <= S_POPW;
          end else if (!sel_q) begin
            sel_q <= 1'b1; state_q <= S_WINIT;
          end else begin
            cnt_q <= '0; state_q <= S_SCAN;
          end
        end
        S_POPW:  state_q <= S_HEADW;
        S_HEADW: begin
          e_q <= hd_rd; state_q <= S_EDGE;
        end
        S_EDGE: begin
          if ((e_q != '0) && (32'(e_q) <= 32'(MAX_EDGES))) state_q <= S_EDGEW;
          else state_q <= S_POP;
        end
        S_EDGEW: begin
          src_q <= ed_src; e_q <= ed_next;
          state_q <= in_use(ed_src, nt) ? S_SEENW : S_EDGE;
        end
        S_SEENW: begin
          if (!seen_sel && (32'(wr_q) < 32'(MAX_NODES))) wr_q <= wr_q + 1'b1;
          state_q <= S_EDGE;
        end
        S_SCAN: begin
          if (32'(cnt_q) < 32'(nt)) state_q <= S_SCANW;
          else begin
            out_valid_q <= 1'b1; state_q <= S_IDLE;
          end
        end
        S_SCANW: begin
          if (s1_rd && s2_rd) begin
            shared_q <= 1'b1; out_valid_q <= 1'b1; state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1; state_q <= S_SCAN;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, shared_q, cls_q, rs_q, rf_q, acc_q};

  // ---------------------------------------------------------------------------
  // Storage
  // ---------------------------------------------------------------------------
  drrb_ram #(.Width(EIW), .Depth(MAX_NODES)) u_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra), .rdata_o(hd_rd)
  );
  drrb_ram #(.Width(EDW), .Depth(MAX_EDGES)) u_edge (
    .clk_i, .we_i(ed_we), .waddr_i(ed_wa), .wdata_i(ed_wd), .raddr_i(ed_ra), .rdata_o(ed_rd)
  );
  drrb_ram #(.Width(1), .Depth(MAX_NODES)) u_seen1 (
    .clk_i, .we_i(s1_we), .waddr_i(sn_wa), .wdata_i(sn_wd), .raddr_i(sn_ra), .rdata_o(s1_rd)
  );
  drrb_ram #(.Width(1), .Depth(MAX_NODES)) u_seen2 (
    .clk_i, .we_i(s2_we), .waddr_i(sn_wa), .wdata_i(sn_wd), .raddr_i(sn_ra), .rdata_o(s2_rd)
  );
  drrb_ram #(.Width(ID_W), .Depth(MAX_NODES)) u_ring (
    .clk_i, .we_i(rg_we), .waddr_i(rg_wa), .wdata_i(rg_wd), .raddr_i(rg_ra), .rdata_o(rg_rd)
  );

endmodule

/* rtl/drrb_checker.sv */
// ----------------------------------------------------------------------------
// drrb_checker
// Port-level checks on the result stream of the reachability block.
// ----------------------------------------------------------------------------
`include "dual_root_reachability_bfs_defines.svh"

module drrb_checker
  import drrb_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_tvalid_i,
  input logic                   m_tready_i,
  input logic [OUT_TDATA_W-1:0] m_tdata_i
);

  `DRRB_ASSERT_NXT(a_hold, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i))
  `DRRB_ASSERT_IMP(a_cls, m_tvalid_i, m_tdata_i[4:3] != 2'd3)
  `DRRB_ASSERT_IMP(a_both, m_tvalid_i && m_tdata_i[1] && m_tdata_i[2], m_tdata_i[4:3] == CLASS_BOTH)
  `DRRB_ASSERT_IMP(a_acc, m_tvalid_i && m_tdata_i[0], !m_tdata_i[1] && !m_tdata_i[2])

endmodule

bind dual_root_reachability_bfs drrb_checker u_drrb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

/* tb/sv/dual_root_reachability_bfs_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-root reachability block testbench
// Loads random small graphs, runs both reverse walks and queries the nodes.
// Every result beat is checked field by field against a predictor of the
// edge store, the walks and the shared flag. Configuration changes only
// while the block is idle. Covers refused edges, out-of-range node totals,
// roots and query nodes.
// ----------------------------------------------------------------------------
module dual_root_reachability_bfs_test;
  import drrb_pkg::*;

  localparam int unsigned N_MAX = 1024;
  localparam int unsigned E_MAX = 4096;
  localparam int unsigned ITEM_GOAL = 1850;

  // result beat layout, lowest bit first: accepted, reach first, reach
  // second, class, shared
  typedef struct packed {
    logic       shared;
    logic [1:0] cls;
    logic       rs;
    logic       rf;
    logic       acc;
  } reach_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the edge store, the visited maps and the registers
  // --------------------------------------------------------------------------
  class reach_scoreboard;
    int unsigned adj_head [N_MAX];
    int unsigned link_next [E_MAX];
    int unsigned link_src [E_MAX];
    int unsigned stored;
    bit [N_MAX-1:0] mark_a, mark_b;
    bit both_flag;
    int unsigned nt_reg, r1_reg, r2_reg;
    reach_res_t pending_q[$];
    int unsigned errors, results, refused, walks;

    function new();
      foreach (adj_head[i]) adj_head[i] = 0;
      stored = 0; mark_a = '0; mark_b = '0; both_flag = 0;
      nt_reg = 1024; r1_reg = 1; r2_reg = 1;
      errors = 0; results = 0; refused = 0; walks = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      case (idx)
        REG_NODE_TOTAL:  nt_reg = val;
        REG_ROOT_FIRST:  r1_reg = val;
        REG_ROOT_SECOND: r2_reg = val;
        default: ;
      endcase
    endfunction

    // reverse breadth-first walk; marks every in-use node that reaches root
    function bit [N_MAX-1:0] walk(int unsigned root, int unsigned nt);
      bit [N_MAX-1:0] m;
      int unsigned ring [N_MAX];
      int unsigned rd, wr, cur, e, src;
      m = '0; rd = 0; wr = 0;
      if (root < 1 || root > nt) return m;
      m[root-1] = 1'b1;
      ring[wr] = root; wr++;
      while (rd < wr) begin
        cur = ring[rd]; rd++;
        e = adj_head[cur-1];
        while (e != 0) begin
          src = link_src[e-1];
          if (src >= 1 && src <= nt && !m[src-1] && wr < N_MAX) begin
            m[src-1] = 1'b1;
            ring[wr] = src; wr++;
          end
          e = link_next[e-1];
        end
      end
      return m;
    endfunction

    function void note_beat(cmd_e c, int unsigned tail, int unsigned head,
                            int unsigned q);
      reach_res_t r;
      int unsigned nt;
      nt = (nt_reg > N_MAX) ? N_MAX : nt_reg;
      r = '0;
      case (c)
        CMD_CLEAR: begin
          foreach (adj_head[i]) adj_head[i] = 0;
          stored = 0;
        end
        CMD_ADD: begin
          if (stored < E_MAX && tail >= 1 && tail <= N_MAX && head >= 1 &&
              head <= N_MAX) begin
            link_src[stored] = tail;
            link_next[stored] = adj_head[head-1];
            stored++;
            adj_head[head-1] = stored;
            r.acc = 1'b1;
          end else begin
            refused++;
          end
        end
        CMD_RUN: begin
          mark_a = walk(r1_reg, nt);
          mark_b = walk(r2_reg, nt);
          both_flag = |(mark_a & mark_b);
          walks++;
        end
        default: begin
          if (q >= 1 && q <= nt) begin
            r.rf = mark_a[q-1];
            r.rs = mark_b[q-1];
          end
          if (r.rf && r.rs) r.cls = CLASS_BOTH;
          else if (r.rf || r.rs || both_flag) r.cls = CLASS_ONE;
          else r.cls = CLASS_NEITHER;
        end
      endcase
      r.shared = both_flag;
      pending_q.push_back(r);
    endfunction

    function void check_beat(logic [OUT_TDATA_W-1:0] data);
      reach_res_t got, want;
      got = data[5:0];
      results++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing outstanding: %h", data);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.acc !== want.acc) begin
        $error("edge_accepted: exp %0d got %0d", want.acc, got.acc); errors++;
      end
      if (got.rf !== want.rf) begin
        $error("reaches_first: exp %0d got %0d", want.rf, got.rf); errors++;
      end
      if (got.rs !== want.rs) begin
        $error("reaches_second: exp %0d got %0d", want.rs, got.rs); errors++;
      end
      if (got.cls !== want.cls) begin
        $error("node_class: exp %0d got %0d", want.cls, got.cls); errors++;
      end
      if (got.shared !== want.shared) begin
        $error("shared_exists: exp %0d got %0d", want.shared, got.shared);
        errors++;
      end
      if (data[OUT_TDATA_W-1:6] !== '0) begin
        $error("pad bits: exp 0 got %h", data[OUT_TDATA_W-1:6]); errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [ID_W-1:0]        cfg_data_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  reach_scoreboard sb = new();
  bit calm = 1'b0;        // no idling on either side in the final stretch
  int unsigned sent = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  dual_root_reachability_bfs i_dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  // result monitor: values sampled are those in force before the edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_beat(m_axis_tdata_o);
  end

  // receiver: random stall bursts, always ready once calm
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(1, 15);
      if (!calm && $urandom_range(0, 2) == 0) m_axis_tready_i <= 1'b0;
      else m_axis_tready_i <= 1'b1;
      repeat (n) @(posedge clk_i);
    end
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  // one input beat; tvalid stays high afterwards until the next beat idles or settle drops it
  task automatic send(cmd_e c, int unsigned tail = 0, int unsigned head = 0,
                      int unsigned q = 0);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {5'b0, q[ID_W-1:0], head[ID_W-1:0], tail[ID_W-1:0], c};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_beat(c, tail & 11'h7FF, head & 11'h7FF, q & 11'h7FF);
    sent++;
  endtask

  // drop tvalid and let every outstanding result arrive
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // all three registers back to back; only legal while settled
  task automatic write_regs(int unsigned nt, int unsigned r1, int unsigned r2);
    int unsigned v [3];
    v[0] = nt; v[1] = r1; v[2] = r2;
    for (int i = 0; i < 3; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[CFG_IDX_W-1:0];
      cfg_data_i <= v[i][ID_W-1:0];
      @(posedge clk_i);
      sb.set_reg(i[CFG_IDX_W-1:0], v[i] & 11'h7FF);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int unsigned pick_node(int unsigned nt);
    int unsigned top;
    top = (nt + 2 > N_MAX) ? N_MAX : nt + 2;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2047);
    return $urandom_range(1, (top < 1) ? 1 : top);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned nt, r1, r2, k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset registers, queries before any run, empty-graph run
    send(CMD_QUERY, 0, 0, 1);
    send(CMD_RUN);
    send(CMD_QUERY, 0, 0, 1);
    send(CMD_QUERY, 0, 0, 0);
    send(CMD_QUERY, 0, 0, 2047);
    send(CMD_QUERY, 0, 0, 1024);
    settle();
    // top node ids, refused endpoints (zero and above the store)
    write_regs(1024, 1024, 1);
    send(CMD_ADD, 1024, 1);
    send(CMD_ADD, 1, 1024);
    send(CMD_ADD, 0, 5);
    send(CMD_ADD, 7, 0);
    send(CMD_ADD, 2047, 2047);
    send(CMD_ADD, 1000, 1024);
    send(CMD_RUN);
    send(CMD_QUERY, 0, 0, 1000);
    send(CMD_QUERY, 0, 0, 7);
    settle();
    // node total above the store acts as full; endpoints above node total
    write_regs(2047, 2, 3);
    send(CMD_ADD, 3, 2);
    send(CMD_RUN);
    send(CMD_QUERY, 0, 0, 3);
    settle();
    write_regs(2, 2, 3);
    send(CMD_RUN);
    send(CMD_QUERY, 0, 0, 3);
    send(CMD_CLEAR);          // maps and shared flag survive a clear
    send(CMD_QUERY, 0, 0, 2);
    settle();
    // no nodes in use, roots out of range
    write_regs(0, 0, 2047);
    send(CMD_RUN);
    send(CMD_QUERY, 0, 0, 1);
    settle();

    // random phases: configure, build a small graph, walk, query
    while (sent < ITEM_GOAL) begin
      if (sent > ITEM_GOAL * 4 / 5) calm = 1'b1;
      k = $urandom_range(0, 9);
      if (k < 7) nt = $urandom_range(2, 40);
      else if (k < 9) nt = $urandom_range(41, 1024);
      else nt = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1025, 2047);
      r1 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 40);
      r2 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 40);
      if (nt >= 2 && nt <= 1024 && $urandom_range(0, 7) != 0) begin
        r1 = $urandom_range(1, nt);
        r2 = $urandom_range(1, nt);
      end
      write_regs(nt, r1, r2);
      if ($urandom_range(0, 3) != 0) send(CMD_CLEAR);
      k = $urandom_range(0, 50);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 19) == 0)
          send(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 2047),
               $urandom_range(0, 2047), $urandom_range(0, 2047));
        else
          send(CMD_ADD, pick_node(nt > 40 ? 40 : nt), pick_node(nt > 40 ? 40 : nt));
      end
      send(CMD_RUN);
      k = $urandom_range(4, 16);
      for (int i = 0; i < k; i++) send(CMD_QUERY, 0, 0, pick_node(nt > 40 ? 40 : nt));
      settle();
    end

    settle();
    repeat (20) @(posedge clk_i);
    $display("covered: %0d results, %0d refused edges, %0d walk runs",
             sb.results, sb.refused, sb.walks);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/drrb_pkg.sv
rtl/drrb_ram.sv
rtl/dual_root_reachability_bfs.sv
rtl/drrb_checker.sv
tb/sv/dual_root_reachability_bfs_test.sv
